// ----- hdl/pwb_pkg.sv -----
package pwb_pkg;

  // Input action codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;
  localparam logic [1:0] ACT_FLUSH = 2'd3;

  // Result kind codes
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_BYTE   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Dirty flags are packed into words of this many pages
  localparam int WORD_W     = 32;
  localparam int WORD_BIT_W = 5;

  // Bus address of the device after reset
  localparam logic [6:0] TARGET_RESET = 7'd80;

endpackage

// ----- hdl/pwb_ram.sv -----
module pwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/pwb_ctrl.sv -----
module pwb_ctrl #(
  parameter int STORE_BYTES = 4096,
  parameter int PG_BYTES    = 32,
  parameter int EFF_PAGES   = 128,
  parameter int NW          = 4,
  parameter int AW_D        = 12,
  parameter int WI_W        = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic [15:0]               in_byte_address,
  input  logic [7:0]                in_write_data,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_value,
  output logic [15:0]               out_page_start,
  output logic [6:0]                out_bus_target,
  output logic                      out_last,
  output logic                      out_more_dirty,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [6:0]                cfg_target_address,
  // byte store
  output logic                      st_we,
  output logic [AW_D-1:0]           st_waddr,
  output logic [7:0]                st_wdata,
  output logic                      st_re,
  output logic [AW_D-1:0]           st_raddr,
  input  logic [7:0]                st_rdata,
  // dirty flag words
  output logic                      dt_we,
  output logic [WI_W-1:0]           dt_waddr,
  output logic [pwb_pkg::WORD_W-1:0] dt_wdata,
  output logic                      dt_re,
  output logic [WI_W-1:0]           dt_raddr,
  input  logic [pwb_pkg::WORD_W-1:0] dt_rdata
);

  import pwb_pkg::*;

  localparam int IX_W  = (PG_BYTES > 1) ? $clog2(PG_BYTES) : 1;
  localparam int CNT_W = $clog2(EFF_PAGES + 1);
  localparam int PG_W  = WI_W + WORD_BIT_W;
  // addr / PG_BYTES as a multiply by a rounded-up reciprocal, exact for 16-bit addresses
  localparam int DIV_S = 22;
  localparam longint DIV_M = ((64'd1 << DIV_S) + PG_BYTES - 1) / PG_BYTES;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_OUT, ST_WR_CMP, ST_WR_SET, ST_ND_OUT,
    ST_SCAN_RD, ST_SCAN_CHK, ST_HDR, ST_BYTE_RD, ST_BYTE_OUT
  } state_t;

  state_t              state_r;
  logic [AW_D-1:0]     clr_cnt_r;
  logic                is_write_r;
  logic [15:0]         addr_r;
  logic [7:0]          data_r;
  logic [15:0]         page_r;
  logic                in_rng_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [WI_W-1:0]     lo_r;
  logic [WI_W-1:0]     scan_w_r;
  logic [15:0]         start_r;
  logic                more_r;
  logic [IX_W-1:0]     idx_r;
  logic                byte_rng_r;
  logic [6:0]          target_r;

  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [7:0]          out_value_r;
  logic [15:0]         out_page_start_r;
  logic [6:0]          out_bus_target_r;
  logic                out_last_r;
  logic                out_more_r;

  logic                accept;
  logic                out_free;
  logic                clearing;
  logic [38:0]         div_prod;
  logic                wr_change;
  logic                set_need;
  logic [WORD_BIT_W-1:0] set_bit;
  logic [WI_W-1:0]     set_word;
  logic                flag_hit;
  logic [WORD_BIT_W-1:0] low_pos;
  logic                found;
  logic [PG_W-1:0]     found_page;
  logic [21:0]         found_start;
  logic [16:0]         byte_addr;
  logic                fin;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign clearing = (state_r == ST_CLEAR);
  assign cfg_ready = 1'b1;

  // page number of the incoming address
  assign div_prod = 39'(in_byte_address) * 39'(DIV_M);

  // write path: byte changed, and its page flag must be set
  assign wr_change = in_rng_r && (st_rdata != data_r);
  assign set_need  = (state_r == ST_WR_CMP) && wr_change && is_write_r &&
                     ({1'b0, page_r} < 17'(EFF_PAGES));
  assign set_bit   = page_r[WORD_BIT_W-1:0];
  assign set_word  = page_r[PG_W-1:WORD_BIT_W];
  assign flag_hit  = dt_rdata[set_bit];

  // lowest set flag in the scanned word
  always_comb begin
    low_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (dt_rdata[i]) low_pos = WORD_BIT_W'(i);
    end
  end

  assign found       = |dt_rdata;
  assign found_page  = {scan_w_r, low_pos};
  assign found_start = 22'(found_page) * 22'(PG_BYTES);
  assign byte_addr   = {1'b0, start_r} + 17'(idx_r);
  assign fin         = (idx_r == IX_W'(PG_BYTES - 1));

  // byte store ports
  always_comb begin
    st_we    = clearing || ((state_r == ST_WR_CMP) && wr_change);
    st_waddr = clearing ? clr_cnt_r : addr_r[AW_D-1:0];
    st_wdata = clearing ? 8'd0 : data_r;
    st_re    = accept || (state_r == ST_BYTE_RD);
    st_raddr = (state_r == ST_BYTE_RD) ? byte_addr[AW_D-1:0] : in_byte_address[AW_D-1:0];
  end

  // dirty word ports
  always_comb begin
    dt_we    = 1'b0;
    dt_waddr = scan_w_r;
    dt_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        dt_we    = ({1'b0, clr_cnt_r} < (AW_D + 1)'(NW));
        dt_waddr = clr_cnt_r[WI_W-1:0];
      end
      ST_WR_SET: begin
        dt_we    = !flag_hit;
        dt_waddr = set_word;
        dt_wdata = dt_rdata | (WORD_W'(1) << set_bit);
      end
      ST_SCAN_CHK: begin
        dt_we    = found;
        dt_waddr = scan_w_r;
        dt_wdata = dt_rdata & ~(WORD_W'(1) << low_pos);
      end
      default: begin
        dt_we = 1'b0;
      end
    endcase
    dt_re    = set_need || (state_r == ST_SCAN_RD);
    dt_raddr = (state_r == ST_SCAN_RD) ? scan_w_r : set_word;
  end

  // sequencer, bookkeeping and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      lo_r        <= '0;
      target_r    <= TARGET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        target_r <= cfg_target_address;
      end
      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW_D'(STORE_BYTES - 1)) begin
            state_r <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            addr_r     <= in_byte_address;
            data_r     <= in_write_data;
            page_r     <= div_prod[DIV_S+15:DIV_S];
            in_rng_r   <= ({1'b0, in_byte_address} < 17'(STORE_BYTES));
            is_write_r <= (in_action == ACT_WRITE);
            scan_w_r   <= lo_r;
            case (in_action)
              ACT_READ:  state_r <= ST_RD_OUT;
              ACT_WRITE,
              ACT_FILL:  state_r <= ST_WR_CMP;
              ACT_FLUSH: state_r <= (cnt_r == '0) ? ST_ND_OUT : ST_SCAN_RD;
              default:   state_r <= ST_IDLE;
            endcase
          end
        end

        ST_RD_OUT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_kind_r       <= KIND_READ;
            out_value_r      <= in_rng_r ? st_rdata : 8'd0;
            out_page_start_r <= '0;
            out_bus_target_r <= '0;
            out_last_r       <= 1'b1;
            out_more_r       <= 1'b0;
            state_r          <= ST_IDLE;
          end
        end

        ST_WR_CMP: begin
          state_r <= set_need ? ST_WR_SET : ST_IDLE;
        end

        ST_WR_SET: begin
          if (!flag_hit) begin
            cnt_r <= cnt_r + 1'b1;
            if (set_word < lo_r) lo_r <= set_word;
          end
          state_r <= ST_IDLE;
        end

        ST_ND_OUT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_kind_r       <= KIND_NONE;
            out_value_r      <= '0;
            out_page_start_r <= '0;
            out_bus_target_r <= '0;
            out_last_r       <= 1'b1;
            out_more_r       <= 1'b0;
            state_r          <= ST_IDLE;
          end
        end

        ST_SCAN_RD: begin
          state_r <= ST_SCAN_CHK;
        end

        ST_SCAN_CHK: begin
          if (found) begin
            cnt_r   <= cnt_r - 1'b1;
            more_r  <= (cnt_r > CNT_W'(1));
            lo_r    <= scan_w_r;
            start_r <= found_start[15:0];
            state_r <= ST_HDR;
          end else begin
            scan_w_r <= scan_w_r + 1'b1;
            state_r  <= ST_SCAN_RD;
          end
        end

        ST_HDR: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_kind_r       <= KIND_HEADER;
            out_value_r      <= '0;
            out_page_start_r <= start_r;
            out_bus_target_r <= target_r;
            out_last_r       <= 1'b0;
            out_more_r       <= 1'b0;
            idx_r            <= '0;
            state_r          <= ST_BYTE_RD;
          end
        end

        ST_BYTE_RD: begin
          byte_rng_r <= (byte_addr < 17'(STORE_BYTES));
          state_r    <= ST_BYTE_OUT;
        end

        ST_BYTE_OUT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_kind_r       <= KIND_BYTE;
            out_value_r      <= byte_rng_r ? st_rdata : 8'd0;
            out_page_start_r <= start_r;
            out_bus_target_r <= target_r;
            out_last_r       <= fin;
            out_more_r       <= fin && more_r;
            idx_r            <= idx_r + 1'b1;
            state_r          <= fin ? ST_IDLE : ST_BYTE_RD;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_value      = out_value_r;
  assign out_page_start = out_page_start_r;
  assign out_bus_target = out_bus_target_r;
  assign out_last       = out_last_r;
  assign out_more_dirty = out_more_r;

endmodule

// ----- hdl/page_writeback_buffer.sv -----
// Byte-wide write-back shadow of a paged memory device with one dirty flag
// per page below PG_LIMIT. Bytes live in a STORE_BYTES x 8 synchronous RAM,
// dirty flags in a RAM of 32-flag words; a running count of dirty pages gives
// "nothing dirty" and "more dirty" at once. After reset the block clears all
// STORE_BYTES bytes and the flag words before it takes the first transaction
// (configuration writes are taken throughout). Each transaction is handled
// alone, paced by the registered reads of the RAMs: a read gives its result
// from an output state; a write or fill compares the stored byte and, when it
// marks a page dirty, sets the flag in a further state; a flush with nothing
// dirty gives its empty result from an output state. A flush of a dirty page
// reads and checks each flag word in turn (the scan starts at the lowest word
// that can hold a dirty flag), sends the header, then reads and sends each
// page byte in turn. A stalled result holds the next one back.
module page_writeback_buffer #(
  parameter int STORE_BYTES = 4096,
  parameter int PG_BYTES    = 32,
  parameter int PG_LIMIT    = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_byte_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [15:0] out_page_start,
  output logic [6:0]  out_bus_target,
  output logic        out_last,
  output logic        out_more_dirty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_target_address
);

  import pwb_pkg::*;

  // pages that can actually be marked
  localparam int PAGES_RAW = (STORE_BYTES + PG_BYTES - 1) / PG_BYTES;
  localparam int EFF_PAGES = (PG_LIMIT < PAGES_RAW) ? PG_LIMIT : PAGES_RAW;
  localparam int NW        = (EFF_PAGES + WORD_W - 1) / WORD_W;
  localparam int WI_W      = (NW > 1) ? $clog2(NW) : 1;
  localparam int AW_D      = $clog2(STORE_BYTES);

  logic              st_we;
  logic [AW_D-1:0]   st_waddr;
  logic [7:0]        st_wdata;
  logic              st_re;
  logic [AW_D-1:0]   st_raddr;
  logic [7:0]        st_rdata;
  logic              dt_we;
  logic [WI_W-1:0]   dt_waddr;
  logic [WORD_W-1:0] dt_wdata;
  logic              dt_re;
  logic [WI_W-1:0]   dt_raddr;
  logic [WORD_W-1:0] dt_rdata;

  // byte store
  pwb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES),
    .AW    (AW_D)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // dirty flag words
  pwb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NW),
    .AW    (WI_W)
  ) u_dirty (
    .clk   (clk),
    .we    (dt_we),
    .waddr (dt_waddr),
    .wdata (dt_wdata),
    .re    (dt_re),
    .raddr (dt_raddr),
    .rdata (dt_rdata)
  );

  pwb_ctrl #(
    .STORE_BYTES (STORE_BYTES),
    .PG_BYTES    (PG_BYTES),
    .EFF_PAGES   (EFF_PAGES),
    .NW          (NW),
    .AW_D        (AW_D),
    .WI_W        (WI_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_byte_address    (in_byte_address),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_value          (out_value),
    .out_page_start     (out_page_start),
    .out_bus_target     (out_bus_target),
    .out_last           (out_last),
    .out_more_dirty     (out_more_dirty),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_target_address (cfg_target_address),
    .st_we              (st_we),
    .st_waddr           (st_waddr),
    .st_wdata           (st_wdata),
    .st_re              (st_re),
    .st_raddr           (st_raddr),
    .st_rdata           (st_rdata),
    .dt_we              (dt_we),
    .dt_waddr           (dt_waddr),
    .dt_wdata           (dt_wdata),
    .dt_re              (dt_re),
    .dt_raddr           (dt_raddr),
    .dt_rdata           (dt_rdata)
  );

endmodule

// ----- hdl/pwb_checker.sv -----
module pwb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_value,
  input logic [15:0] out_page_start,
  input logic [6:0]  out_bus_target,
  input logic        out_last,
  input logic        out_more_dirty
);

  import pwb_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_value) &&
      $stable(out_last))
    else $error("result changed while stalled");

  // read data carries no page information and ends its transaction
  a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_READ |->
      out_last && out_page_start == 16'd0 && out_bus_target == 7'd0 && !out_more_dirty)
    else $error("malformed read result");

  // a header is never the last result of a flush
  a_header_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_HEADER |-> !out_last && !out_more_dirty && out_value == 8'd0)
    else $error("malformed page header");

  // nothing-dirty is a single empty result
  a_none_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NONE |-> out_last && out_value == 8'd0 && !out_more_dirty)
    else $error("malformed nothing-dirty result");

  // more-dirty only on the closing page byte
  a_more_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_more_dirty |-> out_last && out_kind == KIND_BYTE)
    else $error("more-dirty outside the last page byte");

endmodule

bind page_writeback_buffer pwb_checker u_pwb_checker (.*);

// ----- verif/tb_page_writeback_buffer.sv -----
`timescale 1ns / 1ps

module tb_page_writeback_buffer;
  import pwb_pkg::*;

  localparam int DEV_BYTES   = 4096;
  localparam int PAGE_BYTES  = 32;
  localparam int PAGE_TOTAL  = 128;
  // Covers the clearing pass after reset with a wide margin
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          drain;
  } wb_request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [15:0] page_start;
    logic [6:0]  bus_target;
    logic        last;
    logic        more_dirty;
  } wb_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_READ;
  logic [15:0] in_byte_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic [15:0] out_page_start;
  logic [6:0]  out_bus_target;
  logic        out_last;
  logic        out_more_dirty;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_target_address = '0;

  // Shadow copy of the block's state
  logic [7:0]            shadow_mem [0:DEV_BYTES-1];
  logic [PAGE_TOTAL-1:0] dirty_pages = '0;
  logic [6:0]            dev_target = TARGET_RESET;

  wb_request_t queued_requests [$];
  wb_result_t  owed_results [$];
  bit          results_pending = 1'b0;
  int          fail_count = 0;
  int          requests_made = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          quiet_cycles = 0;
  logic [31:0] stall_bits = '0;
  logic [5:0]  stall_tick = '0;

  page_writeback_buffer #(
    .STORE_BYTES(DEV_BYTES),
    .PG_BYTES   (PAGE_BYTES),
    .PG_LIMIT   (PAGE_TOTAL)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_byte_address   (in_byte_address),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_page_start    (out_page_start),
    .out_bus_target    (out_bus_target),
    .out_last          (out_last),
    .out_more_dirty    (out_more_dirty),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_target_address(cfg_target_address)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic string describe(input wb_result_t r);
    return $sformatf("kind=%0d value=%02h start=%04h target=%0d last=%0b more=%0b",
                     r.kind, r.value, r.page_start, r.bus_target, r.last, r.more_dirty);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // Apply one accepted transaction to the shadow state and queue what it owes
  task automatic mirror_request(input logic [1:0] action, input logic [15:0] addr,
                                input logic [7:0] data);
    int unsigned a;
    int unsigned pg;
    int unsigned base;
    int unsigned i;
    bit          more;
    wb_result_t  r;
    a = addr;
    r = '0;
    case (action)
      ACT_READ: begin
        r.kind  = KIND_READ;
        r.value = (a < DEV_BYTES) ? shadow_mem[a] : 8'h00;
        r.last  = 1'b1;
        owed_results.push_back(r);
      end
      ACT_WRITE, ACT_FILL: begin
        // out-of-range and unchanged writes leave everything as is
        if (a < DEV_BYTES && shadow_mem[a] != data) begin
          shadow_mem[a] = data;
          pg = a / PAGE_BYTES;
          if (action == ACT_WRITE && pg < PAGE_TOTAL) begin
            dirty_pages[pg] = 1'b1;
          end
        end
      end
      default: begin
        if (dirty_pages == '0) begin
          r.kind = KIND_NONE;
          r.last = 1'b1;
          owed_results.push_back(r);
        end else begin
          pg = 0;
          while (!dirty_pages[pg]) begin
            pg++;
          end
          dirty_pages[pg] = 1'b0;
          more = |dirty_pages;
          base = pg * PAGE_BYTES;
          r.kind       = KIND_HEADER;
          r.page_start = base[15:0];
          r.bus_target = dev_target;
          owed_results.push_back(r);
          r.kind = KIND_BYTE;
          for (i = 0; i < PAGE_BYTES; i++) begin
            r.value      = (base + i < DEV_BYTES) ? shadow_mem[base + i] : 8'h00;
            r.last       = (i == PAGE_BYTES - 1);
            r.more_dirty = r.last && more;
            owed_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic enqueue_request(input logic [1:0] action, input logic [15:0] addr,
                                 input logic [7:0] data, input bit drain);
    wb_request_t q;
    q.action = action;
    q.addr   = addr;
    q.data   = data;
    q.drain  = drain || ($urandom_range(0, 29) == 0);
    queued_requests.push_back(q);
    requests_made++;
  endtask

  function automatic logic [7:0] pick_byte();
    // small values make repeated (unchanged) writes likely
    return ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
  endfunction

  // Mostly a burst of writes into one page, an optional read back and flushes;
  // sometimes a single transaction with fully random fields
  task automatic add_random_episode();
    int unsigned pg;
    int unsigned n;
    if ($urandom_range(0, 9) < 7) begin
      pg = $urandom_range(0, PAGE_TOTAL - 1);
      n  = $urandom_range(1, 6);
      repeat (n) begin
        enqueue_request(($urandom_range(0, 3) == 0) ? ACT_FILL : ACT_WRITE,
                        16'(pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1)),
                        pick_byte(), 1'b0);
      end
      if ($urandom_range(0, 1) == 0) begin
        enqueue_request(ACT_READ, 16'(pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1)),
                        8'($urandom), 1'b0);
      end
      n = $urandom_range(0, 2);
      repeat (n) begin
        enqueue_request(ACT_FLUSH, 16'($urandom), 8'($urandom), 1'b0);
      end
    end else begin
      enqueue_request(2'($urandom), 16'($urandom), 8'($urandom), 1'b0);
    end
  endtask

  // Block until no transaction is queued, in flight or owed, then let it settle
  task automatic wait_quiet();
    do begin
      @(posedge clk);
    end while (queued_requests.size() != 0 || in_valid || results_pending);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_target(input logic [6:0] v);
    @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_target_address <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    dev_target = v;
  endtask

  task automatic run_random_phase(input logic [6:0] target);
    int goal;
    wait_quiet();
    write_target(target);
    goal = requests_made + 35;
    while (requests_made < goal) begin
      add_random_episode();
    end
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin : drive_proc
    bit took;
    took = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        took = 1'b1;
        queued_requests.delete(0);
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      // a stalled transaction holds its payload
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() == 0 ||
                     (queued_requests[0].drain && (took || results_pending))) begin
          in_valid <= 1'b0;
        end else begin
          in_valid        <= 1'b1;
          in_action       <= queued_requests[0].action;
          in_byte_address <= queued_requests[0].addr;
          in_write_data   <= queued_requests[0].data;
        end
      end
    end
  end

  // Receiver stall: a rotating pattern, reloaded each time stall_tick wraps
  always @(posedge clk) begin
    if (stall_tick == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_bits <= '0;
        1:       stall_bits <= $urandom;
        2:       stall_bits <= $urandom & $urandom;
        default: stall_bits <= $urandom | $urandom;
      endcase
    end else begin
      stall_bits <= {stall_bits[0], stall_bits[31:1]};
    end
    stall_tick <= stall_tick + 1'b1;
    out_stall  <= stall_bits[0];
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin : check_proc
    wb_result_t got;
    wb_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        mirror_request(in_action, in_byte_address, in_write_data);
      end
      if (out_valid && !out_stall) begin
        got = {out_kind, out_value, out_page_start, out_bus_target, out_last,
               out_more_dirty};
        if (owed_results.size() == 0) begin
          note_failure($sformatf("unexpected result %s", describe(got)));
        end else begin
          want = owed_results.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.page_start !== want.page_start || got.bus_target !== want.bus_target ||
              got.last !== want.last || got.more_dirty !== want.more_dirty) begin
            note_failure($sformatf("expected %s, got %s", describe(want), describe(got)));
          end
        end
      end
    end
    results_pending <= (owed_results.size() != 0);
  end

  // Watchdog: no transaction on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    for (i = 0; i < DEV_BYTES; i++) begin
      shadow_mem[i] = 8'h00;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset target address
    enqueue_request(ACT_READ,  16'h0000, 8'h00, 1'b0);
    enqueue_request(ACT_FLUSH, 16'h0000, 8'h00, 1'b0);  // nothing dirty yet
    enqueue_request(ACT_WRITE, 16'h0000, 8'h00, 1'b0);  // same value, no mark
    enqueue_request(ACT_FLUSH, 16'hffff, 8'hff, 1'b1);
    enqueue_request(ACT_FILL,  16'h0021, 8'haa, 1'b0);  // stored, not marked
    enqueue_request(ACT_WRITE, 16'h0fff, 8'hff, 1'b0);  // last byte of device
    enqueue_request(ACT_WRITE, 16'h1000, 8'h55, 1'b0);  // just past the device
    enqueue_request(ACT_FILL,  16'hffff, 8'h01, 1'b0);
    enqueue_request(ACT_READ,  16'hffff, 8'h00, 1'b0);
    enqueue_request(ACT_READ,  16'h0fff, 8'h00, 1'b0);
    enqueue_request(ACT_WRITE, 16'h0028, 8'h5a, 1'b0);
    enqueue_request(ACT_READ,  16'h0021, 8'h00, 1'b0);
    enqueue_request(ACT_FLUSH, 16'h0000, 8'h00, 1'b1);  // page 1, more dirty
    enqueue_request(ACT_FLUSH, 16'h0000, 8'h00, 1'b0);  // last page
    enqueue_request(ACT_FLUSH, 16'h0000, 8'h00, 1'b0);
    enqueue_request(ACT_WRITE, 16'h0fff, 8'hff, 1'b0);  // unchanged again
    enqueue_request(ACT_FLUSH, 16'h0000, 8'h00, 1'b0);
    enqueue_request(ACT_WRITE, 16'h0000, 8'h80, 1'b0);
    enqueue_request(ACT_WRITE, 16'h001f, 8'h7f, 1'b0);
    enqueue_request(ACT_WRITE, 16'h0fe0, 8'h01, 1'b0);
    enqueue_request(ACT_FLUSH, 16'h0000, 8'h00, 1'b0);
    enqueue_request(ACT_FLUSH, 16'h0000, 8'h00, 1'b0);
    enqueue_request(ACT_READ,  16'h8000, 8'h00, 1'b0);
    enqueue_request(ACT_READ,  16'h001f, 8'h00, 1'b0);

    // Random phases across target address settings
    run_random_phase(7'd0);
    run_random_phase(7'd127);
    run_random_phase(7'($urandom_range(1, 126)));
    run_random_phase(7'($urandom));

    wait_quiet();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pwb_pkg.sv
hdl/pwb_ram.sv
hdl/pwb_ctrl.sv
hdl/page_writeback_buffer.sv
hdl/pwb_checker.sv
verif/tb_page_writeback_buffer.sv
